/* sv/normalized_cross_correlation_unit_defines.svh */
// assertion helpers shared by the checker
`ifndef NORMALIZED_CROSS_CORRELATION_UNIT_DEFINES_SVH
`define NORMALIZED_CROSS_CORRELATION_UNIT_DEFINES_SVH

// same-cycle implication
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ncc_pkg.sv */
package ncc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int QBITS       = 15;
  localparam int QTOP        = 14;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_RUN,
    ACC_LAST
  } acc_state_t;

  typedef enum logic [3:0] {
    CORE_IDLE,
    CORE_VX_A,
    CORE_VX_B,
    CORE_VH_A,
    CORE_VH_B,
    CORE_T_A,
    CORE_T_B,
    CORE_PR,
    CORE_NN,
    CORE_S_A,
    CORE_S_B,
    CORE_S_C,
    CORE_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SUM,
    TOP_CALC,
    TOP_HOLD
  } top_state_t;

endpackage

/* sv/ncc_acc.sv */
module ncc_acc #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   tpl_we,
  input  logic [$clog2(MAX_TAPS)-1:0]            tpl_waddr,
  input  logic                                   win_we,
  input  logic [$clog2(MAX_TAPS)-1:0]            win_waddr,
  input  logic [ncc_pkg::SAMPLE_BITS-1:0]        wdata,
  input  logic                                   start,
  input  logic [$clog2(MAX_TAPS+1)-1:0]          n,
  input  logic [$clog2(MAX_TAPS)-1:0]            base,
  output logic                                   done,
  output logic [ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0]   sx,
  output logic [ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0]   sh,
  output logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] sxx,
  output logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] shh,
  output logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] sxh
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int SB = ncc_pkg::SAMPLE_BITS;
  localparam int SW = SB + CW;
  localparam int QW = 2 * SB + CW;

  logic [SB-1:0] tpl_mem [MAX_TAPS];
  logic [SB-1:0] win_mem [MAX_TAPS];
  logic [SB-1:0] x_q, h_q;

  ncc_pkg::acc_state_t state_r, state_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [2*SB-1:0] prod_r, prod_nxt;
  logic [SW-1:0]   sx_r, sx_nxt, sh_r, sh_nxt;
  logic [QW-1:0]   sxx_r, sxx_nxt, shh_r, shh_nxt, sxh_r, sxh_nxt;

  always_ff @(posedge clk) begin
    if (tpl_we) tpl_mem[tpl_waddr] <= wdata;
    if (win_we) win_mem[win_waddr] <= wdata;
    x_q <= win_mem[rd_r];
    h_q <= tpl_mem[k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncc_pkg::ACC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    phase_r <= phase_nxt;
    k_r     <= k_nxt;
    rd_r    <= rd_nxt;
    prod_r  <= prod_nxt;
    sx_r    <= sx_nxt;
    sh_r    <= sh_nxt;
    sxx_r   <= sxx_nxt;
    shh_r   <= shh_nxt;
    sxh_r   <= sxh_nxt;
  end

  // each tap steps through read, x*x, h*h, x*h on one multiplier
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    rd_nxt    = rd_r;
    prod_nxt  = prod_r;
    sx_nxt    = sx_r;
    sh_nxt    = sh_r;
    sxx_nxt   = sxx_r;
    shh_nxt   = shh_r;
    sxh_nxt   = sxh_r;
    done      = 1'b0;
    case (state_r)
      ncc_pkg::ACC_IDLE: begin
        if (start) begin
          state_nxt = ncc_pkg::ACC_RUN;
          phase_nxt = 2'd0;
          k_nxt     = '0;
          rd_nxt    = base;
          sx_nxt    = '0;
          sh_nxt    = '0;
          sxx_nxt   = '0;
          shh_nxt   = '0;
          sxh_nxt   = '0;
        end
      end
      ncc_pkg::ACC_RUN: begin
        phase_nxt = phase_r + 2'd1;
        case (phase_r)
          2'd0: begin
            if (k_r != '0) sxh_nxt = sxh_r + QW'(prod_r);
          end
          2'd1: begin
            prod_nxt = x_q * x_q;
            sx_nxt   = sx_r + SW'(x_q);
            sh_nxt   = sh_r + SW'(h_q);
          end
          2'd2: begin
            sxx_nxt  = sxx_r + QW'(prod_r);
            prod_nxt = h_q * h_q;
          end
          default: begin
            shh_nxt  = shh_r + QW'(prod_r);
            prod_nxt = x_q * h_q;
            if ((k_r + CW'(1)) == n) begin
              state_nxt = ncc_pkg::ACC_LAST;
            end else begin
              k_nxt  = k_r + CW'(1);
              rd_nxt = (rd_r == AW'(MAX_TAPS - 1)) ? '0 : rd_r + AW'(1);
            end
          end
        endcase
      end
      ncc_pkg::ACC_LAST: begin
        sxh_nxt   = sxh_r + QW'(prod_r);
        done      = 1'b1;
        state_nxt = ncc_pkg::ACC_IDLE;
      end
      default: state_nxt = ncc_pkg::ACC_IDLE;
    endcase
  end

  assign sx  = sx_r;
  assign sh  = sh_r;
  assign sxx = sxx_r;
  assign shh = shh_r;
  assign sxh = sxh_r;

endmodule

/* sv/ncc_core.sv */
module ncc_core #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(MAX_TAPS+1)-1:0]          n,
  input  logic [ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0]   sx,
  input  logic [ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0]   sh,
  input  logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] sxx,
  input  logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] shh,
  input  logic [2*ncc_pkg::SAMPLE_BITS+$clog2(MAX_TAPS+1)-1:0] sxh,
  output logic                                   done,
  output logic signed [ncc_pkg::OUT_BITS-1:0]    correlation,
  output logic                                   degenerate
);

  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int QW = 2 * ncc_pkg::SAMPLE_BITS + CW;
  localparam int VW = QW + CW + 1;
  localparam int W  = 2 * VW + 34;

  ncc_pkg::core_state_t state_r, state_nxt;

  logic signed [W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic signed [W-1:0] p_r, p_nxt, r_r, r_nxt, a_r, a_nxt;
  logic signed [W-1:0] bs_r, bs_nxt, ps_r, ps_nxt, cand_r, cand_nxt, bs_pre;
  logic [VW-1:0]       mplier_r, mplier_nxt, vx_r, vx_nxt, vh_r, vh_nxt;
  logic [VW-1:0]       num_r, num_nxt;
  logic                sub_r, sub_nxt, neg_r, neg_nxt, degen_r, degen_nxt;
  logic [ncc_pkg::QBITS-1:0] c_r, c_nxt;
  logic [3:0]          k_r, k_nxt;
  logic                accept;

  // the shared add/subtract unit
  logic signed [W-1:0] add_a, add_b, add_sum;
  logic                add_sub;
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + W'(add_sub);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncc_pkg::CORE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    sub_r    <= sub_nxt;
    vx_r     <= vx_nxt;
    vh_r     <= vh_nxt;
    num_r    <= num_nxt;
    neg_r    <= neg_nxt;
    degen_r  <= degen_nxt;
    p_r      <= p_nxt;
    r_r      <= r_nxt;
    a_r      <= a_nxt;
    bs_r     <= bs_nxt;
    ps_r     <= ps_nxt;
    cand_r   <= cand_nxt;
    c_r      <= c_nxt;
    k_r      <= k_nxt;
  end

  assign accept = (cand_r <= r_r) && !c_r[ncc_pkg::QTOP];

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    sub_nxt    = sub_r;
    vx_nxt     = vx_r;
    vh_nxt     = vh_r;
    num_nxt    = num_r;
    neg_nxt    = neg_r;
    degen_nxt  = degen_r;
    p_nxt      = p_r;
    r_nxt      = r_r;
    a_nxt      = a_r;
    bs_nxt     = bs_r;
    ps_nxt     = ps_r;
    cand_nxt   = cand_r;
    c_nxt      = c_r;
    k_nxt      = k_r;
    add_a      = acc_r;
    add_b      = mcand_r;
    add_sub    = sub_r;
    bs_pre     = bs_r;
    done       = 1'b0;
    case (state_r)
      ncc_pkg::CORE_IDLE: begin
        if (start) begin
          acc_nxt    = '0;
          mcand_nxt  = W'(sxx);
          mplier_nxt = VW'(n);
          sub_nxt    = 1'b0;
          neg_nxt    = 1'b0;
          degen_nxt  = 1'b0;
          c_nxt      = '0;
          state_nxt  = ncc_pkg::CORE_VX_A;
        end
      end
      ncc_pkg::CORE_VX_A, ncc_pkg::CORE_VX_B, ncc_pkg::CORE_VH_A, ncc_pkg::CORE_VH_B,
      ncc_pkg::CORE_T_A, ncc_pkg::CORE_T_B, ncc_pkg::CORE_PR, ncc_pkg::CORE_NN: begin
        if (mplier_r != '0) begin
          // shift-add multiply step
          if (mplier_r[0]) acc_nxt = add_sum;
          mcand_nxt  = mcand_r <<< 1;
          mplier_nxt = mplier_r >> 1;
        end else begin
          case (state_r)
            ncc_pkg::CORE_VX_A: begin
              mcand_nxt  = W'(sx);
              mplier_nxt = VW'(sx);
              sub_nxt    = 1'b1;
              state_nxt  = ncc_pkg::CORE_VX_B;
            end
            ncc_pkg::CORE_VX_B: begin
              vx_nxt     = acc_r[VW-1:0];
              acc_nxt    = '0;
              mcand_nxt  = W'(shh);
              mplier_nxt = VW'(n);
              sub_nxt    = 1'b0;
              state_nxt  = ncc_pkg::CORE_VH_A;
            end
            ncc_pkg::CORE_VH_A: begin
              mcand_nxt  = W'(sh);
              mplier_nxt = VW'(sh);
              sub_nxt    = 1'b1;
              state_nxt  = ncc_pkg::CORE_VH_B;
            end
            ncc_pkg::CORE_VH_B: begin
              vh_nxt = acc_r[VW-1:0];
              if (vx_r == '0 || acc_r == '0) begin
                degen_nxt = 1'b1;
                state_nxt = ncc_pkg::CORE_DONE;
              end else begin
                acc_nxt    = '0;
                mcand_nxt  = W'(sxh);
                mplier_nxt = VW'(n);
                sub_nxt    = 1'b0;
                state_nxt  = ncc_pkg::CORE_T_A;
              end
            end
            ncc_pkg::CORE_T_A: begin
              mcand_nxt  = W'(sx);
              mplier_nxt = VW'(sh);
              sub_nxt    = 1'b1;
              state_nxt  = ncc_pkg::CORE_T_B;
            end
            ncc_pkg::CORE_T_B: begin
              // magnitude of the covariance term
              add_a      = '0;
              add_b      = acc_r;
              add_sub    = 1'b1;
              neg_nxt    = acc_r[W-1];
              num_nxt    = acc_r[W-1] ? add_sum[VW-1:0] : acc_r[VW-1:0];
              acc_nxt    = '0;
              mcand_nxt  = W'(vx_r);
              mplier_nxt = vh_r;
              sub_nxt    = 1'b0;
              state_nxt  = ncc_pkg::CORE_PR;
            end
            ncc_pkg::CORE_PR: begin
              p_nxt      = acc_r;
              acc_nxt    = '0;
              mcand_nxt  = W'(num_r);
              mplier_nxt = num_r;
              state_nxt  = ncc_pkg::CORE_NN;
            end
            default: begin
              // set up the bitwise search for the rounded quotient
              add_a     = '0;
              add_b     = p_r;
              add_sub   = 1'b1;
              r_nxt     = acc_r <<< 30;
              a_nxt     = p_r;
              bs_nxt    = add_sum <<< (ncc_pkg::QTOP + 2);
              ps_nxt    = p_r <<< (2 * ncc_pkg::QTOP + 2);
              c_nxt     = '0;
              k_nxt     = 4'(ncc_pkg::QTOP);
              state_nxt = ncc_pkg::CORE_S_A;
            end
          endcase
        end
      end
      ncc_pkg::CORE_S_A: begin
        add_a     = a_r;
        add_b     = bs_r;
        add_sub   = 1'b0;
        cand_nxt  = add_sum;
        state_nxt = ncc_pkg::CORE_S_B;
      end
      ncc_pkg::CORE_S_B: begin
        add_a     = cand_r;
        add_b     = ps_r;
        add_sub   = 1'b0;
        cand_nxt  = add_sum;
        state_nxt = ncc_pkg::CORE_S_C;
      end
      ncc_pkg::CORE_S_C: begin
        add_a   = bs_r;
        add_b   = ps_r <<< 1;
        add_sub = 1'b0;
        if (accept) begin
          bs_pre = add_sum;
          a_nxt  = cand_r;
          c_nxt  = c_r | (ncc_pkg::QBITS'(1) << k_r);
        end
        bs_nxt = bs_pre >>> 1;
        ps_nxt = ps_r >>> 2;
        if (k_r == '0) begin
          state_nxt = ncc_pkg::CORE_DONE;
        end else begin
          k_nxt     = k_r - 4'd1;
          state_nxt = ncc_pkg::CORE_S_A;
        end
      end
      ncc_pkg::CORE_DONE: begin
        done      = 1'b1;
        state_nxt = ncc_pkg::CORE_IDLE;
      end
      default: state_nxt = ncc_pkg::CORE_IDLE;
    endcase
  end

  assign correlation = neg_r ? (ncc_pkg::OUT_BITS'(0) - ncc_pkg::OUT_BITS'(c_r))
                             : ncc_pkg::OUT_BITS'(c_r);
  assign degenerate  = degen_r;

endmodule

/* sv/normalized_cross_correlation_unit.sv */
// load, clear, unused action and a push that leaves the window short: no result
// a push that completes a window: tap sums on one 16x16 multiplier, then eight shift-add
// multiplies that each run until the multiplier is shifted out, a bitwise search for the
// 15 quotient bits and a done state, all on one wide adder; a degenerate window skips the
// last four multiplies and the search; in_stall is high until the result is registered
// synchronous rst_n clears counts, pointer and control and sets length 64; memories unreset
module normalized_cross_correlation_unit #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_enable,
  input  logic [6:0]                          cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic signed [ncc_pkg::SAMPLE_BITS-1:0] in_sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ncc_pkg::OUT_BITS-1:0] out_correlation,
  output logic                                out_degenerate
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int SW = ncc_pkg::SAMPLE_BITS + CW;
  localparam int QW = 2 * ncc_pkg::SAMPLE_BITS + CW;

  ncc_pkg::top_state_t state_r, state_nxt;
  logic [6:0]    len_r;
  logic [CW-1:0] tc_r, tc_nxt, wc_r, wc_nxt, wc_inc, n_eff;
  logic [AW-1:0] wp_r, wp_nxt, wp_inc, base;
  logic          out_valid_r, out_valid_nxt;
  logic signed [ncc_pkg::OUT_BITS-1:0] out_corr_r, out_corr_nxt;
  logic          out_degen_r, out_degen_nxt;

  logic          req;
  logic          tpl_we, win_we, acc_start, acc_done, core_done, core_degen;
  logic signed [ncc_pkg::OUT_BITS-1:0] core_corr;
  logic [ncc_pkg::SAMPLE_BITS-1:0] biased;
  logic [SW-1:0] sx, sh;
  logic [QW-1:0] sxx, shh, sxh;
  logic          slot_free;

  assign req      = in_valid && !in_stall;
  assign in_stall = (state_r != ncc_pkg::TOP_IDLE);
  // offset binary keeps all sums unsigned
  assign biased   = in_sample_value ^ {1'b1, {(ncc_pkg::SAMPLE_BITS-1){1'b0}}};

  always_comb begin
    if (len_r < 7'd2) begin
      n_eff = CW'(2);
    end else if (32'(len_r) > MAX_TAPS) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(len_r);
    end
  end

  assign wp_inc = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign wc_inc = (wc_r == CW'(MAX_TAPS)) ? wc_r : wc_r + CW'(1);

  // oldest sample of the window lines up with template entry zero
  always_comb begin
    if (CW'(wp_inc) >= n_eff) begin
      base = AW'(CW'(wp_inc) - n_eff);
    end else begin
      base = AW'(CW'(wp_inc) + CW'(MAX_TAPS) - n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncc_pkg::TOP_IDLE;
      len_r       <= 7'd64;
      tc_r        <= '0;
      wc_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_write_enable) len_r <= cfg_write_data;
      tc_r        <= tc_nxt;
      wc_r        <= wc_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_corr_r  <= out_corr_nxt;
    out_degen_r <= out_degen_nxt;
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    tc_nxt        = tc_r;
    wc_nxt        = wc_r;
    wp_nxt        = wp_r;
    tpl_we        = 1'b0;
    win_we        = 1'b0;
    acc_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_corr_nxt  = out_corr_r;
    out_degen_nxt = out_degen_r;
    case (state_r)
      ncc_pkg::TOP_IDLE: begin
        if (req) begin
          case (ncc_pkg::action_t'(in_action))
            ncc_pkg::ACT_LOAD: begin
              if (tc_r < n_eff) begin
                tpl_we = 1'b1;
                tc_nxt = tc_r + CW'(1);
              end
            end
            ncc_pkg::ACT_PUSH: begin
              win_we = 1'b1;
              wp_nxt = wp_inc;
              wc_nxt = wc_inc;
              if (tc_r >= n_eff && wc_inc >= n_eff) begin
                acc_start = 1'b1;
                state_nxt = ncc_pkg::TOP_SUM;
              end
            end
            ncc_pkg::ACT_CLEAR: begin
              tc_nxt = '0;
              wc_nxt = '0;
              wp_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ncc_pkg::TOP_SUM: begin
        if (acc_done) state_nxt = ncc_pkg::TOP_CALC;
      end
      ncc_pkg::TOP_CALC, ncc_pkg::TOP_HOLD: begin
        if (core_done || state_r == ncc_pkg::TOP_HOLD) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_corr_nxt  = core_corr;
            out_degen_nxt = core_degen;
            state_nxt     = ncc_pkg::TOP_IDLE;
          end else begin
            state_nxt = ncc_pkg::TOP_HOLD;
          end
        end
      end
      default: state_nxt = ncc_pkg::TOP_IDLE;
    endcase
  end

  ncc_acc #(.MAX_TAPS(MAX_TAPS)) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .tpl_we    (tpl_we),
    .tpl_waddr (tc_r[AW-1:0]),
    .win_we    (win_we),
    .win_waddr (wp_r),
    .wdata     (biased),
    .start     (acc_start),
    .n         (n_eff),
    .base      (base),
    .done      (acc_done),
    .sx        (sx),
    .sh        (sh),
    .sxx       (sxx),
    .shh       (shh),
    .sxh       (sxh)
  );

  ncc_core #(.MAX_TAPS(MAX_TAPS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (acc_done),
    .n           (n_eff),
    .sx          (sx),
    .sh          (sh),
    .sxx         (sxx),
    .shh         (shh),
    .sxh         (sxh),
    .done        (core_done),
    .correlation (core_corr),
    .degenerate  (core_degen)
  );

  assign out_valid       = out_valid_r;
  assign out_correlation = out_corr_r;
  assign out_degenerate  = out_degen_r;

endmodule

/* sv/ncc_checker.sv */
`include "normalized_cross_correlation_unit_defines.svh"

module ncc_sva (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] out_correlation,
  input logic              out_degenerate
);

  logic        held;
  logic        degen_out;
  logic        corr_in_range;
  logic [16:0] out_word;

  assign held          = out_valid && out_stall;
  assign degen_out     = out_valid && out_degenerate;
  assign corr_in_range = (out_correlation >= -16'sd16384) && (out_correlation <= 16'sd16384);
  assign out_word      = {out_correlation, out_degenerate};

  `NCC_ASSERT_NEXT(a_out_hold, held, out_valid, "result dropped while stalled")
  `NCC_ASSERT_NEXT(a_out_stable, held, $stable(out_word), "stalled result changed")
  `NCC_ASSERT_NOW(a_degen_zero, degen_out, out_correlation == 16'sd0, "degenerate result not zero")
  `NCC_ASSERT_NOW(a_range, out_valid, corr_in_range, "correlation out of range")

endmodule

bind normalized_cross_correlation_unit ncc_sva u_ncc_sva (.*);

/* sim/ncc_checker.sv */
`timescale 1ns / 100ps

module ncc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_enable,
  input  logic [6:0]  cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic signed [15:0] in_sample_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic signed [15:0] out_correlation,
  input  logic        out_degenerate,
  output int          fail_count,
  output int          pending
);

  localparam int TAPS = 64;

  typedef struct {
    logic signed [15:0] corr;
    logic               degen;
  } corr_result_t;

  corr_result_t expected_corr[$];

  logic [6:0]  length_reg;
  logic [15:0] tmpl_mem [TAPS];
  logic [15:0] win_mem [TAPS];
  int unsigned tmpl_cnt, win_cnt, win_ptr;

  function automatic int unsigned eff_length(logic [6:0] len);
    if (len < 2) return 2;
    if (len > TAPS) return TAPS;
    return len;
  endfunction

  // returns 1 when this request completes a window
  function automatic bit correlate_request(logic [1:0] act, logic signed [15:0] val,
                                           output corr_result_t res);
    logic [15:0]  b;
    int unsigned  n, start;
    logic [63:0]  sx, sxx, sh, shh, sxh, xv, hv;
    logic [255:0] wn, vx, vh, t1, t2, num, p, rhs, d;
    int unsigned  lo, hi, mid;
    bit           neg;
    b = {~val[15], val[14:0]};
    n = eff_length(length_reg);
    res.corr = '0;
    res.degen = 1'b0;
    case (act)
      ncc_pkg::ACT_CLEAR: begin
        tmpl_cnt = 0;
        win_cnt = 0;
        win_ptr = 0;
        return 0;
      end
      ncc_pkg::ACT_LOAD: begin
        if (tmpl_cnt < n) begin
          tmpl_mem[tmpl_cnt] = b;
          tmpl_cnt++;
        end
        return 0;
      end
      ncc_pkg::ACT_PUSH: begin
        win_mem[win_ptr] = b;
        win_ptr = (win_ptr + 1) % TAPS;
        if (win_cnt < TAPS) win_cnt++;
        if (tmpl_cnt < n || win_cnt < n) return 0;
      end
      default: return 0;
    endcase
    sx = 0; sxx = 0; sh = 0; shh = 0; sxh = 0;
    start = (win_ptr + TAPS - n) % TAPS;
    for (int k = 0; k < n; k++) begin
      xv = win_mem[(start + k) % TAPS];
      hv = tmpl_mem[k];
      sx += xv;
      sxx += xv * xv;
      sh += hv;
      shh += hv * hv;
      sxh += xv * hv;
    end
    wn = n;
    vx = wn * sxx - 256'(sx) * sx;
    vh = wn * shh - 256'(sh) * sh;
    if (vx == 0 || vh == 0) begin
      res.degen = 1'b1;
      return 1;
    end
    t1 = wn * sxh;
    t2 = 256'(sx) * sh;
    neg = t1 < t2;
    num = neg ? t2 - t1 : t1 - t2;
    p = vx * vh;
    rhs = (num * num) << 30;
    // largest c with (2c-1)^2 * vx * vh <= 2^30 * num^2
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * p <= rhs) lo = mid;
      else hi = mid - 1;
    end
    res.corr = neg ? -16'(lo) : 16'(lo);
    return 1;
  endfunction

  always @(posedge clk) begin
    corr_result_t res, want;
    if (!rst_n) begin
      length_reg <= 7'd64;
      tmpl_cnt = 0;
      win_cnt = 0;
      win_ptr = 0;
      expected_corr.delete();
    end else begin
      if (cfg_write_enable) length_reg <= cfg_write_data;
      if (in_valid && !in_stall) begin
        if (correlate_request(in_action, in_sample_value, res)) expected_corr.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_corr.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: corr %0d degenerate %0b",
                     out_correlation, out_degenerate);
        end else begin
          want = expected_corr.pop_front();
          if (want.corr !== out_correlation || want.degen !== out_degenerate) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected corr %0d degenerate %0b, got corr %0d degenerate %0b",
                       want.corr, want.degen, out_correlation, out_degenerate);
          end
        end
      end
    end
    pending = expected_corr.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

  final begin
    if (expected_corr.size() != 0) $display("results never arrived: %0d", expected_corr.size());
  end
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT_CYCLES = 6000000;
  localparam int SETTLE_CYCLES = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_enable = 1'b0;
  logic [6:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] in_action = ncc_pkg::ACT_LOAD;
  logic signed [15:0] in_sample_value = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_degenerate;
  logic signed [15:0] out_correlation;
  int fail_count, pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int tmpl_loaded;
  int value_kind;
  logic signed [15:0] const_value;

  normalized_cross_correlation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_correlation(out_correlation), .out_degenerate(out_degenerate)
  );

  ncc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_correlation(out_correlation), .out_degenerate(out_degenerate),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_request(logic [1:0] act, logic signed [15:0] val);
    bit taken;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample_value <= val;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [6:0] len);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= len;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case (value_kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15)) - 16'sd8;
      2: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      default: return const_value;
    endcase
  endfunction

  initial begin
    int n, items, phase_items, r, mode;
    logic [6:0] len;
    items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length 3, extremes, both signs of a perfect match, flat window
    write_length(7'd3);
    send_request(ncc_pkg::ACT_CLEAR, 16'sd0);
    send_request(ncc_pkg::ACT_PUSH, -16'sd32768);
    send_request(ncc_pkg::ACT_LOAD, -16'sd32768);
    send_request(ncc_pkg::ACT_LOAD, 16'sd0);
    send_request(ncc_pkg::ACT_LOAD, 16'sd32767);
    send_request(ncc_pkg::ACT_LOAD, 16'sd1);
    send_request(ncc_pkg::ACT_PUSH, 16'sd0);
    send_request(ncc_pkg::ACT_PUSH, 16'sd32767);
    send_request(ncc_pkg::ACT_PUSH, 16'sd32767);
    send_request(ncc_pkg::ACT_PUSH, 16'sd0);
    send_request(ncc_pkg::ACT_PUSH, -16'sd32768);
    send_request(ncc_pkg::ACT_PUSH, 16'sd7);
    send_request(ncc_pkg::ACT_PUSH, 16'sd7);
    send_request(ncc_pkg::ACT_PUSH, 16'sd7);
    send_request(ncc_pkg::ACT_NOP, 16'h5555);
    send_request(ncc_pkg::ACT_CLEAR, 16'sd0);
    items = 16;

    mode = 0;
    while (items < 1550) begin
      drain_and_settle();
      case (mode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (mode)
        0: len = 7'd0;
        1: len = 7'd1;
        2: len = 7'd64;
        3: len = 7'd127;
        4: len = 7'd65;
        5: len = 7'd2;
        default: len = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(2, 12));
      endcase
      mode++;
      write_length(len);
      n = (len < 2) ? 2 : (len > 64) ? 64 : len;
      send_request(ncc_pkg::ACT_CLEAR, 16'sd0);
      tmpl_loaded = 0;
      value_kind = $urandom_range(0, 3);
      const_value = 16'($urandom);
      phase_items = (n > 16) ? $urandom_range(n + 20, n + 60) : $urandom_range(40, 120);
      for (int i = 0; i < phase_items; i++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) value_kind = $urandom_range(0, 3);
        if (r < 1) begin
          send_request(ncc_pkg::ACT_CLEAR, pick_sample());
          tmpl_loaded = 0;
        end else if (r < 3) begin
          send_request(ncc_pkg::ACT_NOP, 16'($urandom));
        end else if (tmpl_loaded < n || r < 8) begin
          send_request(ncc_pkg::ACT_LOAD, pick_sample());
          tmpl_loaded++;
        end else begin
          send_request(ncc_pkg::ACT_PUSH, pick_sample());
        end
        // occasionally let every outstanding result come back first
        if ($urandom_range(0, 199) == 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
          @(posedge clk);
        end
      end
      items += phase_items + 1;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
